// File: rtl/bfca_pkg.sv
// Package for the best-fit coalescing allocator: payload structs, codes and cell bus types.
// No dependencies.
package bfca_pkg;

    localparam int HEADER_BYTES = 4;
    // pool geometry is fixed by the payload field widths below
    localparam int POOL_BLOCKS  = 256;
    localparam int BLOCK_BYTES  = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOALLOC  = 2'd1,
        ST_BADFREE  = 2'd2
    } status_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_HEAP_ENABLED = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [11:0] req_bytes;
        logic [7:0]  free_block;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] block_addr;
        logic [8:0] block_count;
    } result_t;

    // operation broadcast to the cell row
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_DROP   = 2'd1,
        OP_PLACE  = 2'd2
    } cell_op_t;

endpackage

// File: rtl/bfca_cell.sv
// One extent cell of the sorted free-extent row.
// Depends on bfca_pkg.
module bfca_cell #(
    parameter int AW = 8,
    parameter int LW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 init_first,
    input  bfca_pkg::cell_op_t   op,
    input  logic [AW-1:0]        op_start,
    input  logic [LW-1:0]        op_len,
    input  logic                 drop_here,
    input  logic                 left_ins,
    input  logic                 left_valid,
    input  logic [AW-1:0]        left_start,
    input  logic [LW-1:0]        left_len,
    input  logic                 right_valid,
    input  logic [AW-1:0]        right_start,
    input  logic [LW-1:0]        right_len,
    input  logic                 left_drop,
    output logic                 valid,
    output logic [AW-1:0]        start,
    output logic [LW-1:0]        len,
    output logic                 ins,
    output logic                 dropped
);
    logic          valid_reg, valid_next;
    logic [AW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;

    // insert point: first valid entry with len >= new, or first empty slot
    assign ins     = !valid_reg || (len_reg >= op_len);
    assign dropped = left_drop || drop_here;
    assign valid = valid_reg;
    assign start = start_reg;
    assign len   = len_reg;

    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        len_next   = len_reg;
        unique case (op)
            bfca_pkg::OP_DROP:
            begin
                if (dropped)
                begin
                    valid_next = right_valid;
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            bfca_pkg::OP_PLACE:
            begin
                if (left_ins)
                begin
                    valid_next = left_valid;
                    start_next = left_start;
                    len_next   = left_len;
                end
                else if (ins)
                begin
                    valid_next = 1'b1;
                    start_next = op_start;
                    len_next   = op_len;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= init_first;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= init_first ? LW'(bfca_pkg::POOL_BLOCKS) : '0;
        end
        else
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end
endmodule

// File: rtl/bfca_row.sv
// Row of extent cells; drop and place ripple one position per cell.
// Depends on bfca_pkg and bfca_cell.
module bfca_row #(
    parameter int N  = 128,
    parameter int AW = 8,
    parameter int LW = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bfca_pkg::cell_op_t op,
    input  logic [AW-1:0]      op_start,
    input  logic [LW-1:0]      op_len,
    input  logic [N-1:0]       drop_sel,
    output logic [N-1:0]       valid,
    output logic [AW-1:0]      starts [N],
    output logic [LW-1:0]      lens   [N]
);
    logic [N-1:0] ins, dropped;
    logic [N:0]   ins_chain;

    always_comb
    begin
        ins_chain[0] = 1'b0;
        for (int i = 0; i < N; i++)
            ins_chain[i+1] = ins_chain[i] || ins[i];
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic          lv, rv, ld;
        logic [AW-1:0] ls, rs;
        logic [LW-1:0] ll, rl;
        if (g == 0)
        begin : g_l0
            assign lv = 1'b0; assign ls = '0; assign ll = '0; assign ld = 1'b0;
        end
        else
        begin : g_l
            assign lv = valid[g-1]; assign ls = starts[g-1]; assign ll = lens[g-1];
            assign ld = dropped[g-1];
        end
        if (g == N - 1)
        begin : g_rn
            assign rv = 1'b0; assign rs = '0; assign rl = '0;
        end
        else
        begin : g_r
            assign rv = valid[g+1]; assign rs = starts[g+1]; assign rl = lens[g+1];
        end
        bfca_cell #(.AW(AW), .LW(LW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .init_first  (g == 0),
            .op          (op),
            .op_start    (op_start),
            .op_len      (op_len),
            .drop_here   (drop_sel[g]),
            .left_ins    (ins_chain[g]),
            .left_valid  (lv),
            .left_start  (ls),
            .left_len    (ll),
            .right_valid (rv),
            .right_start (rs),
            .right_len   (rl),
            .left_drop   (ld),
            .valid       (valid[g]),
            .start       (starts[g]),
            .len         (lens[g]),
            .ins         (ins[g]),
            .dropped     (dropped[g])
        );
    end
endmodule

// File: rtl/best_fit_coalescing_allocator_core.sv
// Best-fit coalescing allocator over a pool of fixed-size blocks.
// Each command, allocate and free alike, runs through scan, two drop passes, place pass and result,
// then returns to idle, where busy is low, before the next transfer is taken.
// Reset: one free extent covering the pool, all blocks unallocated, heap enabled.
// The result strobe lasts one cycle; the receiver cannot stall.
// Depends on bfca_pkg, bfca_row.
module best_fit_coalescing_allocator_core #(
    parameter int MAX_EXTENTS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  bfca_pkg::cmd_t      cmd,
    output logic                done,
    output bfca_pkg::result_t   result
);
    localparam int AW = 8;
    localparam int LW = 9;
    localparam int N  = MAX_EXTENTS;
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DROP1 = 6'b000100,
        S_DROP2 = 6'b001000,
        S_PLACE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   heap_en_reg;
    logic [CW-1:0] count_reg, count_next;
    bfca_pkg::cmd_t cmd_reg;
    bfca_pkg::result_t res_reg, res_next;
    logic done_reg;

    logic [N-1:0]  drop_a_reg, drop_a_next, drop_b_reg, drop_b_next;
    logic          do_place_reg, do_place_next;
    logic [AW-1:0] pst_reg, pst_next;
    logic [LW-1:0] plen_reg, plen_next;

    bfca_pkg::cell_op_t op;
    logic [AW-1:0] op_start;
    logic [LW-1:0] op_len;
    logic [N-1:0]  drop_sel, valid;
    logic [AW-1:0] starts [N];
    logic [LW-1:0] lens   [N];

    logic         mark_reg [bfca_pkg::POOL_BLOCKS];
    logic [LW-1:0] glen_mem [bfca_pkg::POOL_BLOCKS];
    logic [LW-1:0] glen_rd_reg;
    logic         mark_rd_reg;
    logic         gl_we;
    logic [AW-1:0] gl_wa;
    logic [LW-1:0] gl_wd;
    logic         mk_we, mk_wd;

    assign pready = 1'b1;
    assign prdata = {31'd0, heap_en_reg};
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_en_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == {bfca_pkg::REG_HEAP_ENABLED, 1'b0})
            heap_en_reg <= pwdata[0];
    end

    // need = ceil((req + header) / block)
    logic [12:0] need_w;
    logic [LW-1:0] need;
    assign need_w = (13'(cmd_reg.req_bytes) + 13'(bfca_pkg::HEADER_BYTES)
                     + 13'(bfca_pkg::BLOCK_BYTES - 1)) / 13'(bfca_pkg::BLOCK_BYTES);
    assign need = (need_w > 13'(bfca_pkg::POOL_BLOCKS)) ? LW'(bfca_pkg::POOL_BLOCKS + 1)
                                                        : LW'(need_w);

    // parallel match across cells
    logic [N-1:0] fit, lo_hit, hi_hit, fit_first;
    logic [LW-1:0] fb_end;
    assign fb_end = LW'(cmd_reg.free_block) + glen_rd_reg;
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            fit[i]    = valid[i] && (lens[i] >= need);
            lo_hit[i] = valid[i] && ((LW'(starts[i]) + lens[i]) == LW'(cmd_reg.free_block));
            hi_hit[i] = valid[i] && !lo_hit[i] && (LW'(starts[i]) == fb_end);
        end
        fit_first = fit & ~(fit - N'(1));
    end

    logic [AW-1:0] fit_st, lo_st, hi_st;
    logic [LW-1:0] fit_len, lo_len, hi_len;
    logic [N-1:0]  lo_last, hi_last, lo_m, hi_m;
    always_comb
    begin
        fit_st = '0; fit_len = '0; lo_st = '0; lo_len = '0; hi_st = '0; hi_len = '0;
        lo_last = '0; hi_last = '0;
        // last hit wins as in a forward scan
        for (int i = 0; i < N; i++)
        begin
            if (fit_first[i])
            begin
                fit_st = starts[i]; fit_len = lens[i];
            end
            if (lo_hit[i])
            begin
                lo_st = starts[i]; lo_len = lens[i]; lo_last = N'(1) << i;
            end
            if (hi_hit[i] && !lo_hit[i])
            begin
                hi_st = starts[i]; hi_len = lens[i]; hi_last = N'(1) << i;
            end
        end
    end
    assign lo_m = lo_last;
    assign hi_m = hi_last;

    always_comb
    begin
        op = bfca_pkg::OP_NONE; drop_sel = '0;
        op_start = pst_reg; op_len = plen_reg;
        unique case (state_reg)
            S_DROP1: if (drop_a_reg != '0)
            begin
                op = bfca_pkg::OP_DROP; drop_sel = drop_a_reg;
            end
            S_DROP2: if (drop_b_reg != '0)
            begin
                op = bfca_pkg::OP_DROP; drop_sel = drop_b_reg;
            end
            S_PLACE: if (do_place_reg) op = bfca_pkg::OP_PLACE;
            default: ;
        endcase
    end

    logic lo_any, hi_any;
    logic [LW-1:0] mlen;
    assign lo_any = |lo_m;
    assign hi_any = |hi_m;
    assign mlen = glen_rd_reg + (hi_any ? hi_len : '0) + (lo_any ? lo_len : '0);

    always_comb
    begin
        state_next = state_reg; count_next = count_reg; res_next = res_reg;
        drop_a_next = drop_a_reg; drop_b_next = drop_b_reg;
        do_place_next = do_place_reg; pst_next = pst_reg; plen_next = plen_reg;
        gl_we = 1'b0; gl_wa = cmd_reg.free_block; gl_wd = need;
        mk_we = 1'b0; mk_wd = 1'b0;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_SCAN;
            S_SCAN:
            begin
                drop_a_next = '0; drop_b_next = '0; do_place_next = 1'b0;
                res_next = '{status: bfca_pkg::ST_OK, block_addr: '0, block_count: '0};
                state_next = S_DROP1;
                if (cmd_reg.mode == bfca_pkg::MODE_ALLOC)
                begin
                    if (!heap_en_reg || cmd_reg.req_bytes == '0 || fit == '0)
                        res_next.status = bfca_pkg::ST_NOALLOC;
                    else
                    begin
                        drop_a_next = fit_first;
                        do_place_next = (fit_len != need);
                        pst_next = fit_st + AW'(need);
                        plen_next = fit_len - need;
                        res_next.block_addr = fit_st;
                        res_next.block_count = need;
                        gl_we = 1'b1; gl_wa = fit_st; gl_wd = need;
                        mk_we = 1'b1; mk_wd = 1'b1;
                        // count: -1 then +1 if remainder
                        count_next = (fit_len != need) ? count_reg : count_reg - CW'(1);
                    end
                end
                else
                begin
                    if (!mark_rd_reg ||
                        (!lo_any && !hi_any && count_reg >= CW'(MAX_EXTENTS)))
                        res_next.status = bfca_pkg::ST_BADFREE;
                    else
                    begin
                        // drop higher index first, then the lower one
                        if (lo_any && hi_any)
                        begin
                            drop_a_next = (lo_m > hi_m) ? lo_m : hi_m;
                            drop_b_next = (lo_m > hi_m) ? hi_m : lo_m;
                        end
                        else
                            drop_a_next = lo_m | hi_m;
                        do_place_next = 1'b1;
                        pst_next = lo_any ? lo_st : cmd_reg.free_block;
                        plen_next = mlen;
                        res_next.block_addr = cmd_reg.free_block;
                        res_next.block_count = glen_rd_reg;
                        mk_we = 1'b1; mk_wd = 1'b0;
                        count_next = count_reg + CW'(1) - CW'(lo_any) - CW'(hi_any);
                    end
                end
            end
            S_DROP1: state_next = S_DROP2;
            S_DROP2: state_next = S_PLACE;
            S_PLACE: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_PLACE);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next; drop_a_reg <= drop_a_next; drop_b_reg <= drop_b_next;
        do_place_reg <= do_place_next; pst_reg <= pst_next; plen_reg <= plen_next;
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < bfca_pkg::POOL_BLOCKS; i++)
                mark_reg[i] <= 1'b0;
        else if (mk_we)
            mark_reg[gl_wa] <= mk_wd;
    end

    // granted length memory, read at the accepted free_block
    always_ff @(posedge clk)
    begin
        if (gl_we)
            glen_mem[gl_wa] <= gl_wd;
        glen_rd_reg <= glen_mem[cmd.free_block];
        mark_rd_reg <= mark_reg[cmd.free_block];
    end

    bfca_row #(.N(N), .AW(AW), .LW(LW)) u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .op_start (op_start),
        .op_len   (op_len),
        .drop_sel (drop_sel),
        .valid    (valid),
        .starts   (starts),
        .lens     (lens)
    );
endmodule

// File: rtl/bfca_checker.sv
// Port-level checker for the allocator core, bound to the top level.
// Depends on bfca_pkg and best_fit_coalescing_allocator_core.
module bfca_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bfca_pkg::result_t result
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result strobe outside a command");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than a cycle");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == bfca_pkg::ST_OK || result.status == bfca_pkg::ST_NOALLOC
                  || result.status == bfca_pkg::ST_BADFREE)) else $error("bad status code");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != bfca_pkg::ST_OK) |-> result.block_count == '0)
        else $error("error result carries a count");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted command did not raise busy");
endmodule

bind best_fit_coalescing_allocator_core bfca_port_checker u_bfca_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: dv/bfca_checker.sv
// Checker for the best-fit coalescing allocator: watches command and result transfers,
// models the free-extent table and compares every result. Depends on bfca_pkg.
module bfca_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  bfca_pkg::cmd_t    cmd,
    input  logic              done,
    input  bfca_pkg::result_t result,
    input  logic              cfg_wr,
    input  logic              cfg_val,
    output int                fail_count,
    output int                pending
);
    localparam int POOL = 256;
    localparam int SLOTS = 128;
    localparam int BLK = 16;

    logic [7:0] ext_base [SLOTS];
    logic [8:0] ext_len [SLOTS];
    int         ext_used;
    logic [8:0] alloc_len [POOL];
    logic       alloc_mark [POOL];
    logic       heap_on;
    bfca_pkg::result_t expected_q [$];

    function automatic void remove_extent(int idx);
        if (idx >= ext_used)
            return;
        for (int i = idx; i + 1 < ext_used; i++)
        begin
            ext_base[i] = ext_base[i + 1];
            ext_len[i] = ext_len[i + 1];
        end
        ext_used--;
    endfunction

    function automatic void insert_extent(int base, int len);
        int pos;
        pos = 0;
        if (ext_used >= SLOTS)
            return;
        while (pos < ext_used && int'(ext_len[pos]) < len)
            pos++;
        for (int i = ext_used; i > pos; i--)
        begin
            ext_base[i] = ext_base[i - 1];
            ext_len[i] = ext_len[i - 1];
        end
        ext_base[pos] = base[7:0];
        ext_len[pos] = len[8:0];
        ext_used++;
    endfunction

    function automatic bfca_pkg::result_t serve_command(bfca_pkg::cmd_t c);
        bfca_pkg::result_t r;
        int need, lo, hi, fb, n, st, len;
        bit found;
        r = '0;
        found = 0;
        if (c.mode == bfca_pkg::MODE_ALLOC)
        begin
            need = (int'(c.req_bytes) + bfca_pkg::HEADER_BYTES + BLK - 1) / BLK;
            if (heap_on && c.req_bytes != 0)
            begin
                for (int i = 0; i < ext_used && !found; i++)
                begin
                    if (int'(ext_len[i]) >= need)
                    begin
                        st = int'(ext_base[i]);
                        len = int'(ext_len[i]) - need;
                        remove_extent(i);
                        if (len != 0)
                            insert_extent(st + need, len);
                        alloc_mark[st] = 1;
                        alloc_len[st] = need[8:0];
                        r.block_addr = st[7:0];
                        r.block_count = need[8:0];
                        found = 1;
                    end
                end
            end
            r.status = found ? bfca_pkg::ST_OK : bfca_pkg::ST_NOALLOC;
        end
        else
        begin
            fb = int'(c.free_block);
            if (!alloc_mark[fb])
                r.status = bfca_pkg::ST_BADFREE;
            else
            begin
                n = int'(alloc_len[fb]);
                lo = ext_used;
                hi = ext_used;
                for (int i = 0; i < ext_used; i++)
                begin
                    if (int'(ext_base[i]) + int'(ext_len[i]) == fb)
                        lo = i;
                    else if (int'(ext_base[i]) == fb + n)
                        hi = i;
                end
                if (lo == ext_used && hi == ext_used && ext_used >= SLOTS)
                    r.status = bfca_pkg::ST_BADFREE;
                else
                begin
                    st = fb;
                    len = n;
                    if (hi < ext_used)
                        len += int'(ext_len[hi]);
                    if (lo < ext_used)
                    begin
                        len += int'(ext_len[lo]);
                        st = int'(ext_base[lo]);
                    end
                    if (lo < ext_used && hi < ext_used)
                    begin
                        if (lo > hi)
                        begin
                            remove_extent(lo);
                            remove_extent(hi);
                        end
                        else
                        begin
                            remove_extent(hi);
                            remove_extent(lo);
                        end
                    end
                    else if (lo < ext_used)
                        remove_extent(lo);
                    else if (hi < ext_used)
                        remove_extent(hi);
                    insert_extent(st, len);
                    alloc_mark[fb] = 0;
                    r.status = bfca_pkg::ST_OK;
                    r.block_addr = fb[7:0];
                    r.block_count = n[8:0];
                end
            end
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        bfca_pkg::result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_q.delete();
            ext_used = 1;
            ext_base[0] = 8'd0;
            ext_len[0] = 9'(POOL);
            for (int i = 0; i < POOL; i++)
            begin
                alloc_mark[i] = 0;
                alloc_len[i] = '0;
            end
            heap_on = 1;
        end
        else
        begin
            // compare before predicting: a result never shares an edge with its own command
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.status !== result.status || want.block_addr !== result.block_addr
                        || want.block_count !== result.block_count)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_wr)
                heap_on = cfg_val;
            if (start && !busy)
                expected_q.push_back(serve_command(cmd));
        end
    end
endmodule

// File: dv/testbench.sv
// Stimulus and verdict for best_fit_coalescing_allocator_core; predictions and compares
// live in bfca_checker. Depends on bfca_pkg, the core and bfca_checker.
module testbench;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    bfca_pkg::cmd_t    cmd = '0;
    logic        done;
    bfca_pkg::result_t result;
    int          fail_count, pending;
    int          cycles = 0;
    logic [7:0]  live_blocks [$];
    bit          calm;

    localparam int CYCLE_LIMIT = 200000;

    best_fit_coalescing_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .cmd(cmd), .done(done), .result(result)
    );

    bfca_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .done(done),
        .result(result), .cfg_wr(psel && penable && pwrite && pready && paddr == '0),
        .cfg_val(pwdata[0]), .fail_count(fail_count), .pending(pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drain();
        start <= 0;
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_heap_enable(logic val);
        psel <= 1;
        pwrite <= 1;
        paddr <= {bfca_pkg::REG_HEAP_ENABLED, 1'b0};
        pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // hold start until the transfer; track granted blocks from the result
    task automatic issue(logic m, logic [11:0] req, logic [7:0] fb);
        if (!calm)
            while ($urandom_range(99) < 32)
            begin
                start <= 0;
                @(posedge clk);
            end
        start <= 1;
        cmd <= '{mode: m, req_bytes: req, free_block: fb};
        do
            @(posedge clk);
        while (busy);
        fork
            begin
                while (!done)
                    @(posedge clk);
                if (m == bfca_pkg::MODE_ALLOC && result.status == bfca_pkg::ST_OK)
                    live_blocks.push_back(result.block_addr);
            end
        join_none
    endtask

    task automatic random_item();
        int idx, pick;
        pick = $urandom_range(99);
        if (pick < 8)
            issue(1'($urandom_range(1)), 12'($urandom), 8'($urandom));
        else if (pick < 52 || live_blocks.size() == 0)
            issue(bfca_pkg::MODE_ALLOC, ($urandom_range(9) == 0) ? 12'($urandom)
                  : 12'($urandom_range(1, 120)), 8'($urandom));
        else
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            issue(bfca_pkg::MODE_FREE, 12'($urandom), live_blocks[idx]);
            live_blocks.delete(idx);
        end
    endtask

    initial
    begin
        calm = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, errors, merges
        issue(bfca_pkg::MODE_ALLOC, 12'd0, 8'hff);
        issue(bfca_pkg::MODE_ALLOC, 12'd4095, 8'h00);
        issue(bfca_pkg::MODE_FREE, 12'hfff, 8'd0);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd255);
        issue(bfca_pkg::MODE_ALLOC, 12'd1, 8'd0);
        issue(bfca_pkg::MODE_ALLOC, 12'd12, 8'd0);
        issue(bfca_pkg::MODE_ALLOC, 12'd13, 8'd0);
        issue(bfca_pkg::MODE_ALLOC, 12'd100, 8'd0);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd1);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd1);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd0);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd2);
        issue(bfca_pkg::MODE_ALLOC, 12'd4076, 8'd0);
        issue(bfca_pkg::MODE_ALLOC, 12'd1, 8'd0);
        drain();
        live_blocks.delete();
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd0);
        drain();
        write_heap_enable(0);
        issue(bfca_pkg::MODE_ALLOC, 12'd10, 8'd0);
        drain();
        write_heap_enable(1);
        // fill with single blocks, free every other to fill the table
        for (int i = 0; i < 256; i++)
            issue(bfca_pkg::MODE_ALLOC, 12'd1, 8'd0);
        drain();
        live_blocks.delete();
        for (int i = 0; i < 256; i += 2)
            issue(bfca_pkg::MODE_FREE, 12'd0, 8'(i));
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd255);
        issue(bfca_pkg::MODE_FREE, 12'd0, 8'd1);
        for (int i = 3; i < 256; i += 2)
            issue(bfca_pkg::MODE_FREE, 12'd0, 8'(i));
        drain();
        for (int phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 1);
            for (int i = 0; i < 200; i++)
                random_item();
            drain();
            write_heap_enable(phase == 2 ? 1'b0 : 1'b1);
        end
        write_heap_enable(1);
        for (int i = 0; i < 100; i++)
            random_item();
        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: best_fit_coalescing_allocator_core.f
rtl/bfca_pkg.sv
rtl/bfca_cell.sv
rtl/bfca_row.sv
rtl/best_fit_coalescing_allocator_core.sv
rtl/bfca_checker.sv
dv/bfca_checker.sv
dv/testbench.sv
